### rtl/core/i2crts_pkg.sv
`default_nettype none
package i2crts_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = 6;

    localparam logic [3:0] RETRY_RESET = 4'd10;
    localparam logic [7:0] READ_BIT    = 8'h01;
    localparam logic [2:0] BS_OK       = 3'd0;
    localparam logic [2:0] BS_NACK     = 3'd4;

    typedef enum logic [1:0] {
        ACT_LOAD,
        ACT_WRITE,
        ACT_READ,
        ACT_BUS
    } act_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_BUS_COLL,
        ERR_WR_COLL,
        ERR_TIMEOUT,
        ERR_NACK,
        ERR_SIZE
    } err_t;

    typedef enum logic [2:0] {
        K_START,
        K_STOP,
        K_SEND,
        K_RECV,
        K_DATA,
        K_DONE,
        K_FAIL
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_WADDR,
        PH_INDEX,
        PH_DATA,
        PH_SUSPEND,
        PH_RESTART,
        PH_RADDR,
        PH_READ,
        PH_STOP
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_EXEC,
        SQ_SEND,
        SQ_DUMP_RD,
        SQ_DUMP_WR,
        SQ_DONE
    } seq_t;

    typedef enum logic [1:0] {BD_HOLD, BD_CLEAR, BD_ONE, BD_INC} bd_op_t;
    typedef enum logic [1:0] {RS_ZERO, RS_BD, RS_DUMP} rsel_t;
    typedef enum logic {WS_SLOT, WS_BD} wsel_t;
    typedef enum logic [2:0] {VS_ZERO, VS_ADDR, VS_ADDR_RD, VS_REG, VS_MEM} vsel_t;
    typedef enum logic [1:0] {NK_ZERO, NK_ONE, NK_NEXT} nsel_t;
    typedef enum logic [1:0] {ES_NONE, ES_BUS, ES_SIZE} esel_t;

    typedef struct packed {
        logic   latch_in;
        logic   begin_xfer;
        bd_op_t bd_op;
        logic   retry_clr;
        logic   retry_inc;
        logic   mem_we;
        wsel_t  mem_wsel;
        logic   mem_re;
        rsel_t  mem_rsel;
        logic   dump_clr;
        logic   dump_inc;
        logic   out_load;
        kind_t  out_kind;
        vsel_t  out_vsel;
        nsel_t  out_nsel;
        esel_t  out_esel;
        logic   out_last;
    } cmd_t;

    typedef struct packed {
        act_t action;
        logic bus_ok;
        logic count_over;
        logic count_zero;
        logic is_read;
        logic bd_ge_count;
        logic bd_next_ge_count;
        logic bd_ok;
        logic retry_avail;
        logic slot_ok;
        logic dump_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

### rtl/core/i2crts_dp.sv
`default_nettype none
module i2crts_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire i2crts_pkg::cmd_t  cmd,
    output i2crts_pkg::sts_t       sts,
    input  wire logic [1:0]        action,
    input  wire logic [7:0]        dev_address,
    input  wire logic [7:0]        reg_index,
    input  wire logic [7:0]        byte_count,
    input  wire logic [4:0]        slot,
    input  wire logic [7:0]        data_byte,
    input  wire logic [2:0]        bus_status,
    input  wire logic              cfg_valid,
    input  wire logic [3:0]        cfg_data,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic [2:0]             kind,
    output logic [7:0]             byte_value,
    output logic                   nack_after,
    output logic [2:0]             error_code,
    output logic [3:0]             retries_used,
    output logic                   last
);
    import i2crts_pkg::*;

    // latched transaction
    act_t        act_reg;
    logic [7:0]  addr_in_reg;
    logic [7:0]  reg_in_reg;
    logic [7:0]  count_in_reg;
    logic [4:0]  slot_reg;
    logic [7:0]  data_reg;
    logic [2:0]  status_reg;

    logic        is_read_reg;
    logic [7:0]  tgt_addr_reg;
    logic [7:0]  tgt_reg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] bd_reg, bd_next;
    logic [3:0]  retry_reg, retry_next;
    logic [3:0]  retry_limit_reg;
    logic [BUF_AW-1:0] dump_reg;

    logic [7:0]  mem [BUFFER_DEPTH];
    logic [7:0]  rdata_reg;
    logic [BUF_AW-1:0] waddr, raddr;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg;
    logic [7:0]  out_val_reg, val_next;
    logic        out_nack_reg, nack_next;
    err_t        out_err_reg, err_next, bus_err;
    logic [3:0]  out_retry_reg;
    logic        out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            act_reg      <= act_t'(action);
            addr_in_reg  <= dev_address;
            reg_in_reg   <= reg_index;
            count_in_reg <= byte_count;
            slot_reg     <= slot;
            data_reg     <= data_byte;
            status_reg   <= bus_status;
        end
    end

    always_comb
    begin
        unique case (cmd.bd_op)
            BD_HOLD:  bd_next = bd_reg;
            BD_CLEAR: bd_next = '0;
            BD_ONE:   bd_next = CNT_W'(1);
            BD_INC:   bd_next = bd_reg + CNT_W'(1);
            default:  bd_next = bd_reg;
        endcase
        if (cmd.retry_clr)
            retry_next = '0;
        else if (cmd.retry_inc)
            retry_next = retry_reg + 4'd1;
        else
            retry_next = retry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_read_reg     <= 1'b0;
            tgt_addr_reg    <= '0;
            tgt_reg_reg     <= '0;
            cnt_reg         <= '0;
            bd_reg          <= '0;
            retry_reg       <= '0;
            retry_limit_reg <= RETRY_RESET;
            dump_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                retry_limit_reg <= cfg_data;
            if (cmd.begin_xfer)
            begin
                is_read_reg  <= (act_reg == ACT_READ);
                tgt_addr_reg <= addr_in_reg;
                tgt_reg_reg  <= reg_in_reg;
                cnt_reg      <= count_in_reg[CNT_W-1:0];
                bd_reg       <= '0;
            end
            else
                bd_reg <= bd_next;
            retry_reg <= retry_next;
            if (cmd.dump_clr)
                dump_reg <= '0;
            else if (cmd.dump_inc)
                dump_reg <= dump_reg + BUF_AW'(1);
            out_valid_reg <= out_valid_next;
        end
    end

    // write buffer, registered read
    always_comb
    begin
        waddr = (cmd.mem_wsel == WS_SLOT) ? BUF_AW'(slot_reg) : bd_reg[BUF_AW-1:0];
        unique case (cmd.mem_rsel)
            RS_ZERO: raddr = '0;
            RS_BD:   raddr = bd_reg[BUF_AW-1:0];
            RS_DUMP: raddr = dump_reg;
            default: raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[waddr] <= data_reg;
        if (cmd.mem_re)
            rdata_reg <= mem[raddr];
    end

    assign bus_err = (status_reg > BS_NACK) ? ERR_TIMEOUT : err_t'(status_reg);

    always_comb
    begin
        unique case (cmd.out_vsel)
            VS_ZERO:    val_next = '0;
            VS_ADDR:    val_next = tgt_addr_reg;
            VS_ADDR_RD: val_next = tgt_addr_reg | READ_BIT;
            VS_REG:     val_next = tgt_reg_reg;
            VS_MEM:     val_next = rdata_reg;
            default:    val_next = '0;
        endcase
        unique case (cmd.out_nsel)
            NK_ZERO: nack_next = 1'b0;
            NK_ONE:  nack_next = (cnt_reg == CNT_W'(1));
            NK_NEXT: nack_next = ({1'b0, bd_reg} + (CNT_W+1)'(2)) == {1'b0, cnt_reg};
            default: nack_next = 1'b0;
        endcase
        unique case (cmd.out_esel)
            ES_NONE: err_next = ERR_NONE;
            ES_BUS:  err_next = bus_err;
            ES_SIZE: err_next = ERR_SIZE;
            default: err_next = ERR_NONE;
        endcase
    end

    assign sts.out_free    = !out_valid_reg || !out_stall;
    assign out_valid_next  = cmd.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg  <= cmd.out_kind;
            out_val_reg   <= val_next;
            out_nack_reg  <= nack_next;
            out_err_reg   <= err_next;
            out_retry_reg <= retry_next;
            out_last_reg  <= cmd.out_last;
        end
    end

    assign sts.action           = act_reg;
    assign sts.bus_ok           = (status_reg == BS_OK);
    assign sts.count_over       = (count_in_reg > 8'(BUFFER_DEPTH));
    assign sts.count_zero       = (cnt_reg == '0);
    assign sts.is_read          = is_read_reg;
    assign sts.bd_ge_count      = (bd_reg >= cnt_reg);
    assign sts.bd_next_ge_count = ({1'b0, bd_reg} + (CNT_W+1)'(1)) >= {1'b0, cnt_reg};
    assign sts.bd_ok            = (bd_reg < CNT_W'(BUFFER_DEPTH));
    assign sts.retry_avail      = (retry_reg < retry_limit_reg);
    assign sts.slot_ok          = ({1'b0, slot_reg} < 6'(BUFFER_DEPTH));
    assign sts.dump_last        = (CNT_W'(dump_reg) + CNT_W'(1)) == cnt_reg;

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign byte_value   = out_val_reg;
    assign nack_after   = out_nack_reg;
    assign error_code   = out_err_reg;
    assign retries_used = out_retry_reg;
    assign last         = out_last_reg;

endmodule
`default_nettype wire

### rtl/core/i2crts_ctrl.sv
`default_nettype none
module i2crts_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  ready,
    input  wire i2crts_pkg::sts_t sts,
    output i2crts_pkg::cmd_t      cmd
);
    import i2crts_pkg::*;

    seq_t   seq_reg, seq_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SQ_IDLE;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
        end
    end

    assign ready = (seq_reg == SQ_IDLE);

    always_comb
    begin
        cmd        = '0;
        seq_next   = seq_reg;
        phase_next = phase_reg;
        unique case (seq_reg)
            SQ_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    seq_next     = SQ_EXEC;
                end
            end
            SQ_EXEC:
            begin
                if (sts.out_free)
                begin
                    seq_next = SQ_IDLE;
                    unique case (sts.action)
                        ACT_LOAD:
                        begin
                            if (phase_reg == PH_IDLE && sts.slot_ok)
                            begin
                                cmd.mem_we   = 1'b1;
                                cmd.mem_wsel = WS_SLOT;
                            end
                        end
                        ACT_WRITE, ACT_READ:
                        begin
                            if (phase_reg == PH_IDLE)
                            begin
                                cmd.retry_clr = 1'b1;
                                cmd.out_load  = 1'b1;
                                cmd.out_last  = 1'b1;
                                if (sts.count_over)
                                begin
                                    cmd.out_kind = K_FAIL;
                                    cmd.out_esel = ES_SIZE;
                                end
                                else
                                begin
                                    cmd.begin_xfer = 1'b1;
                                    cmd.out_kind   = K_START;
                                    phase_next     = PH_START;
                                end
                            end
                        end
                        ACT_BUS:
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                cmd.out_last = 1'b1;
                                if (!sts.bus_ok)
                                begin
                                    cmd.bd_op    = BD_CLEAR;
                                    cmd.out_load = 1'b1;
                                    cmd.out_esel = ES_BUS;
                                    if (sts.retry_avail)
                                    begin
                                        cmd.retry_inc = 1'b1;
                                        cmd.out_kind  = K_START;
                                        phase_next    = PH_START;
                                    end
                                    else
                                    begin
                                        cmd.out_kind = K_FAIL;
                                        phase_next   = PH_IDLE;
                                    end
                                end
                                else
                                begin
                                    unique case (phase_reg)
                                        PH_START:
                                        begin
                                            cmd.out_load = 1'b1;
                                            cmd.out_kind = K_SEND;
                                            cmd.out_vsel = VS_ADDR;
                                            phase_next   = PH_WADDR;
                                        end
                                        PH_WADDR:
                                        begin
                                            cmd.out_load = 1'b1;
                                            cmd.out_kind = K_SEND;
                                            cmd.out_vsel = VS_REG;
                                            phase_next   = PH_INDEX;
                                        end
                                        PH_INDEX:
                                        begin
                                            if (sts.is_read)
                                            begin
                                                cmd.out_load = 1'b1;
                                                cmd.out_kind = K_STOP;
                                                phase_next   = PH_SUSPEND;
                                            end
                                            else if (sts.count_zero)
                                            begin
                                                cmd.out_load = 1'b1;
                                                cmd.out_kind = K_STOP;
                                                phase_next   = PH_STOP;
                                            end
                                            else
                                            begin
                                                cmd.bd_op    = BD_ONE;
                                                cmd.mem_re   = 1'b1;
                                                cmd.mem_rsel = RS_ZERO;
                                                phase_next   = PH_DATA;
                                                seq_next     = SQ_SEND;
                                            end
                                        end
                                        PH_DATA:
                                        begin
                                            if (sts.bd_ge_count)
                                            begin
                                                cmd.out_load = 1'b1;
                                                cmd.out_kind = K_STOP;
                                                phase_next   = PH_STOP;
                                            end
                                            else
                                            begin
                                                cmd.bd_op    = BD_INC;
                                                cmd.mem_re   = 1'b1;
                                                cmd.mem_rsel = RS_BD;
                                                seq_next     = SQ_SEND;
                                            end
                                        end
                                        PH_SUSPEND:
                                        begin
                                            cmd.out_load = 1'b1;
                                            cmd.out_kind = K_START;
                                            phase_next   = PH_RESTART;
                                        end
                                        PH_RESTART:
                                        begin
                                            cmd.out_load = 1'b1;
                                            cmd.out_kind = K_SEND;
                                            cmd.out_vsel = VS_ADDR_RD;
                                            phase_next   = PH_RADDR;
                                        end
                                        PH_RADDR:
                                        begin
                                            cmd.out_load = 1'b1;
                                            if (sts.count_zero)
                                            begin
                                                cmd.out_kind = K_STOP;
                                                phase_next   = PH_STOP;
                                            end
                                            else
                                            begin
                                                cmd.out_kind = K_RECV;
                                                cmd.out_nsel = NK_ONE;
                                                phase_next   = PH_READ;
                                            end
                                        end
                                        PH_READ:
                                        begin
                                            cmd.mem_we   = sts.bd_ok;
                                            cmd.mem_wsel = WS_BD;
                                            cmd.bd_op    = BD_INC;
                                            cmd.out_load = 1'b1;
                                            if (sts.bd_next_ge_count)
                                            begin
                                                cmd.out_kind = K_STOP;
                                                phase_next   = PH_STOP;
                                            end
                                            else
                                            begin
                                                cmd.out_kind = K_RECV;
                                                cmd.out_nsel = NK_NEXT;
                                            end
                                        end
                                        PH_STOP:
                                        begin
                                            phase_next = PH_IDLE;
                                            if (sts.is_read && !sts.count_zero)
                                            begin
                                                cmd.dump_clr = 1'b1;
                                                seq_next     = SQ_DUMP_RD;
                                            end
                                            else
                                            begin
                                                cmd.out_load = 1'b1;
                                                cmd.out_kind = K_DONE;
                                            end
                                        end
                                        default:
                                        begin
                                            phase_next = PH_IDLE;
                                        end
                                    endcase
                                end
                            end
                        end
                        default:
                        begin
                            seq_next = SQ_IDLE;
                        end
                    endcase
                end
            end
            SQ_SEND:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = K_SEND;
                    cmd.out_vsel = VS_MEM;
                    cmd.out_last = 1'b1;
                    seq_next     = SQ_IDLE;
                end
            end
            SQ_DUMP_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.mem_rsel = RS_DUMP;
                seq_next     = SQ_DUMP_WR;
            end
            SQ_DUMP_WR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = K_DATA;
                    cmd.out_vsel = VS_MEM;
                    if (sts.dump_last)
                        seq_next = SQ_DONE;
                    else
                    begin
                        cmd.dump_inc = 1'b1;
                        seq_next     = SQ_DUMP_RD;
                    end
                end
            end
            SQ_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = K_DONE;
                    cmd.out_last = 1'b1;
                    seq_next     = SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded into occupied output register");

    a_final_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SQ_EXEC && cmd.out_load && cmd.out_last) |=> seq_reg == SQ_IDLE)
        else $error("sequencer busy after final result");

    a_dump_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SQ_DUMP_RD || seq_reg == SQ_DUMP_WR) |-> phase_reg == PH_IDLE)
        else $error("read data returned while bus phase active");

    a_rx_store_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_we && cmd.mem_wsel == WS_BD) |->
            (cmd.out_kind == K_STOP || cmd.out_kind == K_RECV))
        else $error("receive byte stored without stop or receive command");

endmodule
`default_nettype wire

### rtl/core/i2c_register_transfer_sequencer.sv
// Register transfer sequencer for a byte-level I2C engine. One transaction is taken at a
// time: it is accepted in SQ_IDLE and executed in SQ_EXEC once the output register is free;
// a command that sends a byte from the write buffer also passes through SQ_SEND, for the
// buffer's registered read port. The bus result that closes a read then returns its N data
// bytes through that same read port, alternating SQ_DUMP_RD and SQ_DUMP_WR, followed by
// done. A stalled output holds the sequencer until the pending result is taken. The write
// buffer needs no clearing after reset; retry_limit resets to 10.
`default_nettype none
module i2c_register_transfer_sequencer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] action,
    input  wire logic [7:0] dev_address,
    input  wire logic [7:0] reg_index,
    input  wire logic [7:0] byte_count,
    input  wire logic [4:0] slot,
    input  wire logic [7:0] data_byte,
    input  wire logic [2:0] bus_status,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      kind,
    output logic [7:0]      byte_value,
    output logic            nack_after,
    output logic [2:0]      error_code,
    output logic [3:0]      retries_used,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data
);
    import i2crts_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic ready;

    assign in_stall  = !ready;
    assign cfg_ready = 1'b1;

    i2crts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .ready    (ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    i2crts_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .action       (action),
        .dev_address  (dev_address),
        .reg_index    (reg_index),
        .byte_count   (byte_count),
        .slot         (slot),
        .data_byte    (data_byte),
        .bus_status   (bus_status),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .kind         (kind),
        .byte_value   (byte_value),
        .nack_after   (nack_after),
        .error_code   (error_code),
        .retries_used (retries_used),
        .last         (last)
    );

endmodule
`default_nettype wire

### verif/tb_i2c_register_transfer_sequencer.sv
`timescale 1ns / 100ps
module tb_i2c_register_transfer_sequencer;
    import i2crts_pkg::*;

    localparam int WR_STEPS    = 4;   // bus results for a write of zero bytes
    localparam int RD_STEPS    = 7;   // bus results for a read of zero bytes
    localparam int RAND_ITEMS  = 130;
    localparam int CFG_QUIET   = 16;
    localparam int TAIL_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] BS_UNKNOWN = 3'd7;

    typedef struct packed {
        act_t       action;
        logic [7:0] addr;
        logic [7:0] ridx;
        logic [7:0] count;
        logic [4:0] slot;
        logic [7:0] data;
        logic [2:0] status;
    } xfer_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       nack;
        err_t       err;
        logic [3:0] retries;
        logic       last;
    } seq_result_t;

    typedef enum {ST_FREE, ST_LIGHT, ST_HEAVY, ST_PERIODIC} stall_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] action;
    logic [7:0] dev_address;
    logic [7:0] reg_index;
    logic [7:0] byte_count;
    logic [4:0] slot;
    logic [7:0] data_byte;
    logic [2:0] bus_status;
    logic       out_valid;
    logic       out_stall = 1'b1;
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic       nack_after;
    logic [2:0] error_code;
    logic [3:0] retries_used;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data = 4'd0;

    xfer_item_t  pending_items[$];
    xfer_item_t  cur_item = '0;
    bit          in_pending = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    bit          drain_hold = 1'b0;

    seq_result_t expected_cmds[$];
    seq_result_t step_cmds[$];
    int          err_count = 0;
    int          gen_count = 0;
    int          cycle_count = 0;
    bit          slot_loaded[BUFFER_DEPTH];

    stall_mode_t stall_mode = ST_FREE;
    int          stall_left = 0;

    // sequencer shadow state
    phase_t      sq_phase = PH_IDLE;
    logic        sq_is_read = 1'b0;
    logic [7:0]  sq_addr = '0;
    logic [7:0]  sq_reg = '0;
    logic [5:0]  sq_count = '0;
    logic [5:0]  sq_done = '0;
    logic [3:0]  sq_retries = '0;
    err_t        sq_last_err = ERR_NONE;
    logic [3:0]  sq_limit = RETRY_RESET;
    logic [7:0]  sq_buf[BUFFER_DEPTH];

    assign action      = cur_item.action;
    assign dev_address = cur_item.addr;
    assign reg_index   = cur_item.ridx;
    assign byte_count  = cur_item.count;
    assign slot        = cur_item.slot;
    assign data_byte   = cur_item.data;
    assign bus_status  = cur_item.status;

    i2c_register_transfer_sequencer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .dev_address  (dev_address),
        .reg_index    (reg_index),
        .byte_count   (byte_count),
        .slot         (slot),
        .data_byte    (data_byte),
        .bus_status   (bus_status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .byte_value   (byte_value),
        .nack_after   (nack_after),
        .error_code   (error_code),
        .retries_used (retries_used),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic add_cmd(input kind_t k, input logic [7:0] v, input logic nk, input err_t e);
        seq_result_t r;
        r.kind    = k;
        r.value   = v;
        r.nack    = nk;
        r.err     = e;
        r.retries = sq_retries;
        r.last    = 1'b0;
        step_cmds.push_back(r);
    endtask

    task automatic sequence_step(input xfer_item_t it);
        seq_result_t r;
        step_cmds.delete();
        case (it.action)
            ACT_LOAD:
            begin
                if (sq_phase == PH_IDLE)
                    sq_buf[it.slot] = it.data;
            end
            ACT_WRITE, ACT_READ:
            begin
                if (sq_phase == PH_IDLE)
                begin
                    sq_retries = '0;
                    if (it.count > BUFFER_DEPTH)
                    begin
                        sq_last_err = ERR_SIZE;
                        add_cmd(K_FAIL, 8'h00, 1'b0, ERR_SIZE);
                    end
                    else
                    begin
                        sq_is_read  = (it.action == ACT_READ);
                        sq_addr     = it.addr;
                        sq_reg      = it.ridx;
                        sq_count    = it.count[5:0];
                        sq_done     = '0;
                        sq_last_err = ERR_NONE;
                        sq_phase    = PH_START;
                        add_cmd(K_START, 8'h00, 1'b0, ERR_NONE);
                    end
                end
            end
            default:
            begin
                if (sq_phase != PH_IDLE && it.status != BS_OK)
                begin
                    sq_last_err = (it.status > BS_NACK) ? ERR_TIMEOUT : err_t'(it.status);
                    sq_done = '0;
                    if (sq_retries < sq_limit)
                    begin
                        sq_retries = sq_retries + 4'd1;
                        sq_phase = PH_START;
                        add_cmd(K_START, 8'h00, 1'b0, sq_last_err);
                    end
                    else
                    begin
                        sq_phase = PH_IDLE;
                        add_cmd(K_FAIL, 8'h00, 1'b0, sq_last_err);
                    end
                end
                else if (sq_phase != PH_IDLE)
                begin
                    case (sq_phase)
                        PH_START:
                        begin
                            sq_phase = PH_WADDR;
                            add_cmd(K_SEND, sq_addr, 1'b0, ERR_NONE);
                        end
                        PH_WADDR:
                        begin
                            sq_phase = PH_INDEX;
                            add_cmd(K_SEND, sq_reg, 1'b0, ERR_NONE);
                        end
                        PH_INDEX:
                        begin
                            if (sq_is_read)
                            begin
                                sq_phase = PH_SUSPEND;
                                add_cmd(K_STOP, 8'h00, 1'b0, ERR_NONE);
                            end
                            else if (sq_count == 0)
                            begin
                                sq_phase = PH_STOP;
                                add_cmd(K_STOP, 8'h00, 1'b0, ERR_NONE);
                            end
                            else
                            begin
                                sq_phase = PH_DATA;
                                sq_done = 6'd1;
                                add_cmd(K_SEND, sq_buf[0], 1'b0, ERR_NONE);
                            end
                        end
                        PH_DATA:
                        begin
                            if (sq_done >= sq_count)
                            begin
                                sq_phase = PH_STOP;
                                add_cmd(K_STOP, 8'h00, 1'b0, ERR_NONE);
                            end
                            else
                            begin
                                add_cmd(K_SEND, sq_buf[sq_done[4:0]], 1'b0, ERR_NONE);
                                sq_done = sq_done + 6'd1;
                            end
                        end
                        PH_SUSPEND:
                        begin
                            sq_phase = PH_RESTART;
                            add_cmd(K_START, 8'h00, 1'b0, ERR_NONE);
                        end
                        PH_RESTART:
                        begin
                            sq_phase = PH_RADDR;
                            add_cmd(K_SEND, sq_addr | READ_BIT, 1'b0, ERR_NONE);
                        end
                        PH_RADDR:
                        begin
                            if (sq_count == 0)
                            begin
                                sq_phase = PH_STOP;
                                add_cmd(K_STOP, 8'h00, 1'b0, ERR_NONE);
                            end
                            else
                            begin
                                sq_phase = PH_READ;
                                add_cmd(K_RECV, 8'h00, sq_count == 6'd1, ERR_NONE);
                            end
                        end
                        PH_READ:
                        begin
                            sq_buf[sq_done[4:0]] = it.data;
                            sq_done = sq_done + 6'd1;
                            if (sq_done >= sq_count)
                            begin
                                sq_phase = PH_STOP;
                                add_cmd(K_STOP, 8'h00, 1'b0, ERR_NONE);
                            end
                            else
                                add_cmd(K_RECV, 8'h00, sq_done + 6'd1 == sq_count, ERR_NONE);
                        end
                        PH_STOP:
                        begin
                            sq_phase = PH_IDLE;
                            if (sq_is_read)
                                for (int i = 0; i < sq_count; i++)
                                    add_cmd(K_DATA, sq_buf[i], 1'b0, ERR_NONE);
                            add_cmd(K_DONE, 8'h00, 1'b0, ERR_NONE);
                        end
                        default:
                            sq_phase = PH_IDLE;
                    endcase
                end
            end
        endcase
        if (step_cmds.size() != 0)
        begin
            r = step_cmds.pop_back();
            r.last = 1'b1;
            step_cmds.push_back(r);
        end
        while (step_cmds.size() != 0)
            expected_cmds.push_back(step_cmds.pop_front());
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // input side: accept at rising edge, feed at falling edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            sequence_step(cur_item);
            in_pending = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_pending)
        begin
            if (drain_hold && expected_cmds.size() != 0)
                in_valid <= 1'b0;
            else if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                drain_hold = 1'b0;
                cur_item = pending_items.pop_front();
                in_pending = 1'b1;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 10);
                    gap_left = $urandom_range(1, 8);
                    drain_hold = ($urandom_range(0, 24) == 0);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 80);
        end
        else
            stall_left--;
        case (stall_mode)
            ST_FREE:  out_stall <= 1'b0;
            ST_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
            ST_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
            default:  out_stall <= (stall_left % 4 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        seq_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cmds.size() == 0)
            begin
                $error("unexpected result transaction, kind %0d", kind);
                err_count++;
            end
            else
            begin
                want = expected_cmds.pop_front();
                check_field("kind", want.kind, kind);
                check_field("byte_value", want.value, byte_value);
                check_field("nack_after", want.nack, nack_after);
                check_field("error_code", want.err, error_code);
                check_field("retries_used", want.retries, retries_used);
                check_field("last", want.last, last);
            end
        end
    end

    task automatic queue_item(input act_t a, input logic [7:0] addr, input logic [7:0] ridx,
                              input logic [7:0] cnt, input logic [4:0] sl,
                              input logic [7:0] d, input logic [2:0] st);
        xfer_item_t it;
        it.action = a;
        it.addr   = addr;
        it.ridx   = ridx;
        it.count  = cnt;
        it.slot   = sl;
        it.data   = d;
        it.status = st;
        pending_items.push_back(it);
        gen_count++;
    endtask

    task automatic queue_bus(input logic [2:0] st);
        queue_item(ACT_BUS, $urandom, $urandom, $urandom, $urandom, $urandom, st);
    endtask

    task automatic queue_load(input logic [4:0] sl, input logic [7:0] d, input bit mark);
        queue_item(ACT_LOAD, $urandom, $urandom, $urandom, sl, d, $urandom);
        if (mark)
            slot_loaded[sl] = 1'b1;
    endtask

    // one complete transfer from idle back to idle, with random bus failures
    task automatic run_transfer(input bit rd, input logic [7:0] cnt, input int err_pct);
        int steps_left;
        int tries;
        if (!rd && cnt <= BUFFER_DEPTH)
            for (int i = 0; i < cnt; i++)
                if (!slot_loaded[i])
                    queue_load(i[4:0], $urandom, 1'b1);
        queue_item(rd ? ACT_READ : ACT_WRITE, $urandom, $urandom, cnt, $urandom, $urandom,
                   $urandom);
        if (cnt <= BUFFER_DEPTH)
        begin
            steps_left = (rd ? RD_STEPS : WR_STEPS) + cnt;
            tries = 0;
            while (steps_left > 0)
            begin
                if ($urandom_range(0, 99) < err_pct)
                begin
                    queue_bus(3'($urandom_range(1, 7)));
                    if (tries < sq_limit)
                    begin
                        tries++;
                        steps_left = (rd ? RD_STEPS : WR_STEPS) + cnt;
                    end
                    else
                        steps_left = -1;
                end
                else
                begin
                    queue_bus(BS_OK);
                    steps_left--;
                end
            end
            if (rd && steps_left == 0)
                for (int i = 0; i < cnt; i++)
                    slot_loaded[i] = 1'b1;
        end
    endtask

    task automatic wait_sent();
        while (pending_items.size() != 0 || in_pending)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        wait_sent();
        while (expected_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_sent();
        while (sq_phase != PH_IDLE)
        begin
            queue_bus(BS_OK);
            wait_sent();
        end
    endtask

    task automatic set_retry_limit(input logic [3:0] v);
        wait_drained();
        repeat (CFG_QUIET) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sq_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_i2c_register_transfer_sequencer: done, errors");
        $finish;
    end

    initial
    begin
        int         pick;
        int         sz;
        int         pre;
        logic [7:0] cnt;
        act_t       a;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        queue_item(ACT_WRITE, $urandom, $urandom, 8'(BUFFER_DEPTH + 1), $urandom, $urandom,
                   $urandom);
        queue_item(ACT_READ, $urandom, $urandom, 8'hFF, $urandom, $urandom, $urandom);
        queue_bus(BS_OK);
        queue_load(5'd0, 8'hFF, 1'b1);
        queue_load(5'd31, 8'h00, 1'b1);
        queue_item(ACT_WRITE, 8'hFF, 8'h00, 8'd0, $urandom, $urandom, $urandom);
        queue_item(ACT_READ, $urandom, $urandom, 8'd1, $urandom, $urandom, $urandom);
        queue_load(5'd1, $urandom, 1'b0);
        repeat (WR_STEPS) queue_bus(BS_OK);
        queue_item(ACT_READ, 8'h00, 8'hFF, 8'd1, $urandom, $urandom, $urandom);
        queue_bus(BS_OK);
        queue_bus(BS_UNKNOWN);
        repeat (RD_STEPS + 1) queue_bus(BS_OK);
        settle();

        // random, one retry_limit setting per phase
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       set_retry_limit(4'd0);
                1:       set_retry_limit(4'd15);
                2:       set_retry_limit(4'($urandom_range(1, 14)));
                default: set_retry_limit(4'($urandom_range(0, 15)));
            endcase
            gen_count = 0;
            while (gen_count < RAND_ITEMS / 4)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    sz = $urandom_range(0, 99);
                    if (sz < 80)
                        cnt = $urandom_range(0, 4);
                    else if (sz < 88)
                        cnt = BUFFER_DEPTH;
                    else if (sz < 95)
                        cnt = $urandom_range(5, BUFFER_DEPTH - 1);
                    else
                        cnt = $urandom_range(BUFFER_DEPTH + 1, 255);
                    run_transfer($urandom_range(0, 1), cnt,
                                 ($urandom_range(0, 9) == 0) ? 40 : 8);
                end
                else if (pick < 80)
                    repeat ($urandom_range(1, 3)) queue_load($urandom, $urandom, 1'b1);
                else
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        a = act_t'($urandom_range(0, 3));
                        case (a)
                            ACT_LOAD:
                                queue_load($urandom, $urandom, 1'b0);
                            ACT_WRITE:
                            begin
                                // never send a buffer entry that was not written
                                pre = 0;
                                while (pre < BUFFER_DEPTH && slot_loaded[pre])
                                    pre++;
                                cnt = $urandom_range(0, 1) ? $urandom_range(BUFFER_DEPTH + 1, 255)
                                                           : $urandom_range(0, pre);
                                queue_item(ACT_WRITE, $urandom, $urandom, cnt, $urandom,
                                           $urandom, $urandom);
                            end
                            ACT_READ:
                                queue_item(ACT_READ, $urandom, $urandom, $urandom_range(0, 40),
                                           $urandom, $urandom, $urandom);
                            default:
                                queue_bus($urandom_range(0, 7));
                        endcase
                    end
                    settle();
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb_i2c_register_transfer_sequencer: done, clean");
        else
            $display("tb_i2c_register_transfer_sequencer: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/core/i2crts_pkg.sv
rtl/core/i2crts_dp.sv
rtl/core/i2crts_ctrl.sv
rtl/core/i2c_register_transfer_sequencer.sv
verif/tb_i2c_register_transfer_sequencer.sv
